### rtl/core/magnetometer_calibrated_heading_core_assert.svh
// Assertion macros for the magnetometer heading core
`ifndef MAGNETOMETER_CALIBRATED_HEADING_CORE_ASSERT_SVH
`define MAGNETOMETER_CALIBRATED_HEADING_CORE_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset
`define MCH_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the core clock and reset
`define MCH_ASSERT(lbl, prop, msg) \
  `MCH_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/mch_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the heading core
package mch_pkg;

  localparam int unsigned MCH_CORDIC_STEPS = 16;
  localparam int unsigned MCH_REG_W        = 48;
  localparam int unsigned MCH_IDX_W        = 2;

  localparam logic [MCH_REG_W-1:0] GAIN_X_RST = 48'h0000_0000_1000;
  localparam logic [MCH_REG_W-1:0] GAIN_Y_RST = 48'h0000_1000_0000;
  localparam logic [MCH_REG_W-1:0] GAIN_Z_RST = 48'h1000_0000_0000;
  localparam logic [MCH_REG_W-1:0] OFFSET_RST = 48'h0000_0000_0000;

  typedef enum logic [MCH_IDX_W-1:0] {
    REG_GAIN_X = 2'd0,
    REG_GAIN_Y = 2'd1,
    REG_GAIN_Z = 2'd2,
    REG_OFFSET = 2'd3
  } mch_reg_e;

  localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [25:0] FULL_TURN = 26'sd23592960;
  localparam logic [15:0]        FULL_Q6   = 16'd23040;

  typedef logic signed [34:0] mch_vec_t;
  typedef logic signed [25:0] mch_ang_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } mch_cal_t;

  function automatic mch_ang_t mch_atan(input logic [4:0] idx);
    mch_ang_t r;
    unique case (idx)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/magnetometer_calibrated_heading_core.sv
// Magnetometer hard/soft-iron calibration with CORDIC heading, fully pipelined
// Accepts one sample triple per cycle and returns one result per cycle while the output side
// takes them; its stages in order: bias subtract, matrix multiply, row sum and saturate, CORDIC
// setup, one stage per CORDIC iteration, angle wrap, and round into the output register. The
// whole pipeline holds while a result waits at the output. Configuration registers feed the
// datapath directly; the user must write them only while the pipeline is empty (not enforced).
module magnetometer_calibrated_heading_core
  import mch_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = MCH_CORDIC_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MCH_IDX_W-1:0] cfg_idx_i,
  input  logic [MCH_REG_W-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,   // sample_x, sample_y, sample_z
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata    // heading, cal_x, cal_y, cal_z, zero pad
);

  localparam int unsigned Lat = CORDIC_STEPS + 6;

  logic [MCH_REG_W-1:0] gain_q [3];
  logic [MCH_REG_W-1:0] offset_q;
  logic [Lat-1:0]       vld_q;
  logic                 adv;

  logic signed [16:0] d_q [3];
  logic signed [16:0] d_d [3];
  logic signed [32:0] p_q [3][3];
  logic signed [32:0] p_d [3][3];
  mch_cal_t           cal_q;
  mch_cal_t           cal_d;

  mch_vec_t x_q   [CORDIC_STEPS+1];
  mch_vec_t y_q   [CORDIC_STEPS+1];
  mch_ang_t z_q   [CORDIC_STEPS+1];
  logic     zer_q [CORDIC_STEPS+1];
  mch_cal_t cc_q  [CORDIC_STEPS+1];

  mch_vec_t x0_d;
  mch_vec_t y0_d;
  mch_ang_t z0_d;

  mch_ang_t zw_q, zw_d;
  logic     zw_zer_q;
  mch_cal_t zw_cal_q;

  logic [14:0] head_q, head_d;
  mch_cal_t    out_cal_q;

  assign adv           = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {1'b0, out_cal_q.z, out_cal_q.y, out_cal_q.x, head_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= GAIN_X_RST;
      gain_q[1] <= GAIN_Y_RST;
      gain_q[2] <= GAIN_Z_RST;
      offset_q  <= OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (mch_reg_e'(cfg_idx_i))
        REG_GAIN_X: gain_q[0] <= cfg_data_i;
        REG_GAIN_Y: gain_q[1] <= cfg_data_i;
        REG_GAIN_Z: gain_q[2] <= cfg_data_i;
        REG_OFFSET: offset_q  <= cfg_data_i;
        default:    offset_q  <= offset_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    logic signed [15:0] smp;
    logic signed [15:0] bias;
    logic signed [15:0] coef;
    logic signed [34:0] acc;
    logic signed [34:0] sh;
    logic signed [15:0] res [3];
    for (int j = 0; j < 3; j++) begin
      smp    = s_axis_tdata[16*j +: 16];
      bias   = offset_q[16*j +: 16];
      d_d[j] = 17'(smp) - 17'(bias);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef      = gain_q[i][16*j +: 16];
        p_d[i][j] = 33'(coef) * 33'(d_q[j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = 35'(p_q[i][0]) + 35'(p_q[i][1]) + 35'(p_q[i][2]) + 35'sd2048;
      sh  = acc >>> 12;
      if (sh > 35'sd32767) begin
        res[i] = 16'sh7fff;
      end else if (sh < -35'sd32768) begin
        res[i] = 16'sh8000;
      end else begin
        res[i] = 16'(sh);
      end
    end
    cal_d.x = res[0];
    cal_d.y = res[1];
    cal_d.z = res[2];
  end

  always_comb begin
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    xs = {cal_q.y, 16'h0000};
    ys = {cal_q.x, 16'h0000};
    if (cal_q.y < 0) begin
      x0_d = -35'(xs);
      y0_d = -35'(ys);
      z0_d = HALF_TURN;
    end else begin
      x0_d = 35'(xs);
      y0_d = 35'(ys);
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q      <= d_d;
      p_q      <= p_d;
      cal_q    <= cal_d;
      x_q[0]   <= x0_d;
      y_q[0]   <= y0_d;
      z_q[0]   <= z0_d;
      zer_q[0] <= (cal_q.x == 16'sd0) && (cal_q.y == 16'sd0);
      cc_q[0]  <= cal_q;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    mch_vec_t xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + mch_atan(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - mch_atan(5'(i));
        end
        zer_q[i+1] <= zer_q[i];
        cc_q[i+1]  <= cc_q[i];
      end
    end
  end

  always_comb begin
    logic [25:0] rnd;
    logic [15:0] q;
    if (z_q[CORDIC_STEPS] < 0) begin
      zw_d = z_q[CORDIC_STEPS] + FULL_TURN;
    end else if (z_q[CORDIC_STEPS] >= FULL_TURN) begin
      zw_d = z_q[CORDIC_STEPS] - FULL_TURN;
    end else begin
      zw_d = z_q[CORDIC_STEPS];
    end
    rnd = 26'(zw_q) + 26'd512;
    q   = 16'(rnd >> 10);
    if (zw_zer_q) begin
      head_d = '0;
    end else if (q >= FULL_Q6) begin
      head_d = 15'(q - FULL_Q6);
    end else begin
      head_d = 15'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zw_q      <= zw_d;
      zw_zer_q  <= zer_q[CORDIC_STEPS];
      zw_cal_q  <= cc_q[CORDIC_STEPS];
      head_q    <= head_d;
      out_cal_q <= zw_cal_q;
    end
  end

endmodule

### rtl/core/mch_checker.sv
// Port-level assertion checker for the heading core, bound to the top level
`include "magnetometer_calibrated_heading_core_assert.svh"

module mch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic [14:0] heading;
  logic [15:0] cal_x;
  logic [15:0] cal_y;
  logic        zero_vec;
  logic        stall;

  assign heading  = m_axis_tdata[14:0];
  assign cal_x    = m_axis_tdata[30:15];
  assign cal_y    = m_axis_tdata[46:31];
  assign zero_vec = (cal_x == '0) && (cal_y == '0);
  assign stall    = m_axis_tvalid && !m_axis_tready;

  `MCH_ASSERT(a_head_range, m_axis_tvalid |-> (heading < 15'd23040), "heading out of range")
  `MCH_ASSERT(a_zero_head, m_axis_tvalid && zero_vec |-> heading == '0, "heading not zero")
  `MCH_ASSERT(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
  `MCH_ASSERT(a_out_hold, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "transaction changed")

endmodule

bind magnetometer_calibrated_heading_core mch_checker u_mch_checker (.*);
